// ===== hw/rtl/rmc_pkg.sv =====
// Package for the ray/mesh closest hit unit: types, constants and the microprogram.
`default_nettype none
package rmc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 32;
  localparam int W_W       = 48;
  localparam int MAG_W     = W_W - 1;
  localparam int EPS_W     = 16;
  localparam int DIST_W    = 31;
  localparam int NORM_W    = 18;
  localparam int DVD_W     = MAG_W + FRAC_BITS;
  localparam int SQ_STEPS  = (DVD_W + 1) / 2;
  localparam int SQ_RAD_W  = 2 * SQ_STEPS;
  localparam int SRW       = SQ_STEPS + 2;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = W_W / MUL_CHUNK;
  localparam int RF_DEPTH  = 64;
  localparam int RF_AW     = 6;
  localparam int PC_W      = 7;
  localparam int NCOORD    = 9;
  localparam int CI_W      = 4;

  typedef logic signed [W_W-1:0] wide_t;

  localparam wide_t WMAX = wide_t'({1'b0, {MAG_W{1'b1}}});
  localparam wide_t ONE = wide_t'(1) <<< FRAC_BITS;
  localparam wide_t DIST_MAX_W = wide_t'({1'b0, {DIST_W{1'b1}}});
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

  // scratch register map
  localparam int R_O = 0, R_D = 3, R_A = 6, R_B = 9, R_C = 12;
  localparam int R_AB = 15, R_AC = 18, R_AO = 21, R_M = 24;
  localparam int R_DET = 27, R_BETA = 28, R_GAMMA = 29, R_T = 30;
  localparam int R_LEN = 34, R_N = 35, R_P1 = 38, R_P2 = 39;
  localparam int R_S = 40, R_DOT = 43, R_SUM = 44;

  localparam logic [PC_W-1:0] PC_RAY = PC_W'(0);
  localparam logic [PC_W-1:0] PC_TRI = PC_W'(8);

  typedef enum logic [3:0] {
    OP_MOVIN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT,
    OP_CHKDET, OP_CHKNN, OP_CHKLE1, OP_CHKT, OP_BRNOK,
    OP_NSET, OP_FIN, OP_RAYCLR, OP_END
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] sa;
    logic [RF_AW-1:0] sb;
  } instr_t;

  typedef struct packed {
    logic   load;
    logic   rd;
    logic   ex;
    logic   unit_wr;
    logic   emit;
    instr_t ins;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic unit_done;
    logic out_busy;
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_WAIT, S_EMIT
  } ctl_state_t;

  function automatic wide_t sat_w(input logic signed [W_W:0] x);
    wide_t r;
    if (x > $signed({WMAX[W_W-1], WMAX})) r = WMAX;
    else if (x < -$signed({WMAX[W_W-1], WMAX})) r = -WMAX;
    else r = x[W_W-1:0];
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input wide_t x);
    wide_t n;
    n = -x;
    return x[W_W-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

  function automatic instr_t mk(input op_t op, input int d, input int a, input int b);
    instr_t i;
    i.op  = op;
    i.dst = RF_AW'(d);
    i.sa  = RF_AW'(a);
    i.sb  = RF_AW'(b);
    return i;
  endfunction

  function automatic instr_t prog(input logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      // ray load
      7'd0: i = mk(OP_MOVIN, R_O + 0, 0, 0);
      7'd1: i = mk(OP_MOVIN, R_O + 1, 1, 0);
      7'd2: i = mk(OP_MOVIN, R_O + 2, 2, 0);
      7'd3: i = mk(OP_MOVIN, R_D + 0, 3, 0);
      7'd4: i = mk(OP_MOVIN, R_D + 1, 4, 0);
      7'd5: i = mk(OP_MOVIN, R_D + 2, 5, 0);
      7'd6: i = mk(OP_RAYCLR, 0, 0, 0);
      // triangle test
      7'd8:  i = mk(OP_MOVIN, R_A + 0, 0, 0);
      7'd9:  i = mk(OP_MOVIN, R_A + 1, 1, 0);
      7'd10: i = mk(OP_MOVIN, R_A + 2, 2, 0);
      7'd11: i = mk(OP_MOVIN, R_B + 0, 3, 0);
      7'd12: i = mk(OP_MOVIN, R_B + 1, 4, 0);
      7'd13: i = mk(OP_MOVIN, R_B + 2, 5, 0);
      7'd14: i = mk(OP_MOVIN, R_C + 0, 6, 0);
      7'd15: i = mk(OP_MOVIN, R_C + 1, 7, 0);
      7'd16: i = mk(OP_MOVIN, R_C + 2, 8, 0);
      7'd17: i = mk(OP_SUB, R_AB + 0, R_A + 0, R_B + 0);
      7'd18: i = mk(OP_SUB, R_AB + 1, R_A + 1, R_B + 1);
      7'd19: i = mk(OP_SUB, R_AB + 2, R_A + 2, R_B + 2);
      7'd20: i = mk(OP_SUB, R_AC + 0, R_A + 0, R_C + 0);
      7'd21: i = mk(OP_SUB, R_AC + 1, R_A + 1, R_C + 1);
      7'd22: i = mk(OP_SUB, R_AC + 2, R_A + 2, R_C + 2);
      7'd23: i = mk(OP_SUB, R_AO + 0, R_A + 0, R_O + 0);
      7'd24: i = mk(OP_SUB, R_AO + 1, R_A + 1, R_O + 1);
      7'd25: i = mk(OP_SUB, R_AO + 2, R_A + 2, R_O + 2);
      // m = (A-B) x (A-C), also the face normal
      7'd26: i = mk(OP_MUL, R_P1, R_AB + 1, R_AC + 2);
      7'd27: i = mk(OP_MUL, R_P2, R_AC + 1, R_AB + 2);
      7'd28: i = mk(OP_SUB, R_M + 0, R_P1, R_P2);
      7'd29: i = mk(OP_MUL, R_P1, R_AC + 0, R_AB + 2);
      7'd30: i = mk(OP_MUL, R_P2, R_AB + 0, R_AC + 2);
      7'd31: i = mk(OP_SUB, R_M + 1, R_P1, R_P2);
      7'd32: i = mk(OP_MUL, R_P1, R_AB + 0, R_AC + 1);
      7'd33: i = mk(OP_MUL, R_P2, R_AC + 0, R_AB + 1);
      7'd34: i = mk(OP_SUB, R_M + 2, R_P1, R_P2);
      7'd35: i = mk(OP_MUL, R_P1, R_D + 0, R_M + 0);
      7'd36: i = mk(OP_MUL, R_P2, R_D + 1, R_M + 1);
      7'd37: i = mk(OP_ADD, R_DET, R_P1, R_P2);
      7'd38: i = mk(OP_MUL, R_P1, R_D + 2, R_M + 2);
      7'd39: i = mk(OP_ADD, R_DET, R_DET, R_P1);
      7'd40: i = mk(OP_CHKDET, 0, R_DET, 0);
      7'd41: i = mk(OP_BRNOK, 0, 0, 0);
      // beta
      7'd42: i = mk(OP_MUL, R_P1, R_AO + 1, R_AC + 2);
      7'd43: i = mk(OP_MUL, R_P2, R_AC + 1, R_AO + 2);
      7'd44: i = mk(OP_SUB, R_S + 0, R_P1, R_P2);
      7'd45: i = mk(OP_MUL, R_P1, R_AC + 0, R_AO + 2);
      7'd46: i = mk(OP_MUL, R_P2, R_AO + 0, R_AC + 2);
      7'd47: i = mk(OP_SUB, R_S + 1, R_P1, R_P2);
      7'd48: i = mk(OP_MUL, R_P1, R_AO + 0, R_AC + 1);
      7'd49: i = mk(OP_MUL, R_P2, R_AC + 0, R_AO + 1);
      7'd50: i = mk(OP_SUB, R_S + 2, R_P1, R_P2);
      7'd51: i = mk(OP_MUL, R_P1, R_D + 0, R_S + 0);
      7'd52: i = mk(OP_MUL, R_P2, R_D + 1, R_S + 1);
      7'd53: i = mk(OP_ADD, R_DOT, R_P1, R_P2);
      7'd54: i = mk(OP_MUL, R_P1, R_D + 2, R_S + 2);
      7'd55: i = mk(OP_ADD, R_DOT, R_DOT, R_P1);
      7'd56: i = mk(OP_DIV, R_BETA, R_DOT, R_DET);
      7'd57: i = mk(OP_CHKNN, 0, R_BETA, 0);
      7'd58: i = mk(OP_BRNOK, 0, 0, 0);
      // gamma
      7'd59: i = mk(OP_MUL, R_P1, R_AB + 1, R_AO + 2);
      7'd60: i = mk(OP_MUL, R_P2, R_AO + 1, R_AB + 2);
      7'd61: i = mk(OP_SUB, R_S + 0, R_P1, R_P2);
      7'd62: i = mk(OP_MUL, R_P1, R_AO + 0, R_AB + 2);
      7'd63: i = mk(OP_MUL, R_P2, R_AB + 0, R_AO + 2);
      7'd64: i = mk(OP_SUB, R_S + 1, R_P1, R_P2);
      7'd65: i = mk(OP_MUL, R_P1, R_AB + 0, R_AO + 1);
      7'd66: i = mk(OP_MUL, R_P2, R_AO + 0, R_AB + 1);
      7'd67: i = mk(OP_SUB, R_S + 2, R_P1, R_P2);
      7'd68: i = mk(OP_MUL, R_P1, R_D + 0, R_S + 0);
      7'd69: i = mk(OP_MUL, R_P2, R_D + 1, R_S + 1);
      7'd70: i = mk(OP_ADD, R_DOT, R_P1, R_P2);
      7'd71: i = mk(OP_MUL, R_P1, R_D + 2, R_S + 2);
      7'd72: i = mk(OP_ADD, R_DOT, R_DOT, R_P1);
      7'd73: i = mk(OP_DIV, R_GAMMA, R_DOT, R_DET);
      7'd74: i = mk(OP_CHKNN, 0, R_GAMMA, 0);
      7'd75: i = mk(OP_ADD, R_SUM, R_BETA, R_GAMMA);
      7'd76: i = mk(OP_CHKLE1, 0, R_SUM, 0);
      7'd77: i = mk(OP_BRNOK, 0, 0, 0);
      // t
      7'd78: i = mk(OP_MUL, R_P1, R_AO + 0, R_M + 0);
      7'd79: i = mk(OP_MUL, R_P2, R_AO + 1, R_M + 1);
      7'd80: i = mk(OP_ADD, R_DOT, R_P1, R_P2);
      7'd81: i = mk(OP_MUL, R_P1, R_AO + 2, R_M + 2);
      7'd82: i = mk(OP_ADD, R_DOT, R_DOT, R_P1);
      7'd83: i = mk(OP_DIV, R_T, R_DOT, R_DET);
      7'd84: i = mk(OP_CHKT, 0, R_T, 0);
      7'd85: i = mk(OP_BRNOK, 0, 0, 0);
      // unit normal
      7'd86: i = mk(OP_MUL, R_P1, R_M + 0, R_M + 0);
      7'd87: i = mk(OP_MUL, R_P2, R_M + 1, R_M + 1);
      7'd88: i = mk(OP_ADD, R_DOT, R_P1, R_P2);
      7'd89: i = mk(OP_MUL, R_P1, R_M + 2, R_M + 2);
      7'd90: i = mk(OP_ADD, R_DOT, R_DOT, R_P1);
      7'd91: i = mk(OP_SQRT, R_LEN, R_DOT, 0);
      7'd92: i = mk(OP_DIV, R_N + 0, R_M + 0, R_LEN);
      7'd93: i = mk(OP_DIV, R_N + 1, R_M + 1, R_LEN);
      7'd94: i = mk(OP_DIV, R_N + 2, R_M + 2, R_LEN);
      7'd95: i = mk(OP_NSET, 0, R_N + 0, 0);
      7'd96: i = mk(OP_NSET, 1, R_N + 1, 0);
      7'd97: i = mk(OP_NSET, 2, R_N + 2, 0);
      7'd98: i = mk(OP_FIN, 0, 0, 0);
      default: i = mk(OP_END, 0, 0, 0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rmc_iter.sv =====
// Shared iterative unit: multiply (16 bits/step), divide (1 bit/step), square root.
`default_nettype none
module rmc_iter import rmc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  op_t   op,
  input  wide_t a,
  input  wide_t b,
  output logic  done,
  output wide_t res
);

  logic                   busy_r, done_r;
  logic [CNT_W-1:0]       cnt_r;
  op_t                    op_r;
  logic                   neg_r;
  logic [MAG_W-1:0]       ma_r, e_r, rem_r;
  logic [W_W-1:0]         mb_r;
  logic [2*W_W-1:0]       acc_r;
  logic [DVD_W-1:0]       dvd_r, q_r;
  logic [SQ_RAD_W-1:0]    rad_r;
  logic [SRW-1:0]         srem_r;
  logic [SQ_STEPS-1:0]    root_r;

  logic [W_W+MUL_CHUNK-1:0] prod;
  logic [2*W_W-1:0]       pm;
  logic [MAG_W:0]         dtrial;
  logic                   dge;
  logic [SRW-1:0]         sr, strial;
  logic                   sge;
  logic [MAG_W-1:0]       rmag;
  logic [W_W-1:0]         smag;

  always_comb begin
    prod   = (W_W+MUL_CHUNK)'({1'b0, ma_r}) *
             (W_W+MUL_CHUNK)'(mb_r[W_W-1 -: MUL_CHUNK]);
    dtrial = {rem_r, dvd_r[DVD_W-1]};
    dge    = dtrial >= {1'b0, e_r};
    sr     = {srem_r[SRW-3:0], rad_r[SQ_RAD_W-1 -: 2]};
    strial = SRW'({root_r, 2'b01});
    sge    = sr >= strial;
    pm     = acc_r >> FRAC_BITS;
    rmag   = '0;
    case (op_r)
      OP_MUL: rmag = (|pm[2*W_W-1:MAG_W]) ? {MAG_W{1'b1}} : pm[MAG_W-1:0];
      OP_DIV: begin
        if (e_r == '0) rmag = '0;
        else rmag = (|q_r[DVD_W-1:MAG_W]) ? {MAG_W{1'b1}} : q_r[MAG_W-1:0];
      end
      default: rmag = '0;
    endcase
    smag = {1'b0, rmag};
    if (op_r == OP_SQRT) res = wide_t'(root_r);
    else res = neg_r ? -wide_t'(smag) : wide_t'(smag);
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        case (op)
          OP_MUL:  cnt_r <= CNT_W'(MUL_STEPS);
          OP_DIV:  cnt_r <= CNT_W'(DVD_W);
          default: cnt_r <= CNT_W'(SQ_STEPS);
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= op;
      neg_r  <= a[W_W-1] ^ b[W_W-1];
      ma_r   <= mag(a);
      mb_r   <= {1'b0, mag(b)};
      e_r    <= mag(b);
      acc_r  <= '0;
      dvd_r  <= {mag(a), {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      q_r    <= '0;
      rad_r  <= a[W_W-1] ? '0 : SQ_RAD_W'({a[MAG_W-1:0], {FRAC_BITS{1'b0}}});
      srem_r <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          acc_r <= (acc_r << MUL_CHUNK) + (2*W_W)'(prod);
          mb_r  <= mb_r << MUL_CHUNK;
        end
        OP_DIV: begin
          dvd_r <= dvd_r << 1;
          q_r   <= {q_r[DVD_W-2:0], dge};
          rem_r <= dge ? MAG_W'(dtrial - {1'b0, e_r}) : dtrial[MAG_W-1:0];
        end
        default: begin
          rad_r  <= rad_r << 2;
          srem_r <= sge ? (sr - strial) : sr;
          root_r <= {root_r[SQ_STEPS-2:0], sge};
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rmc_dp.sv =====
// Datapath: scratch register file, saturating add/sub, hit checks, best-hit state, output beat.
`default_nettype none
module rmc_dp import rmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [EPS_W-1:0]         cfg_wdata,
  input  logic signed [IN_W-1:0]   in_ax,
  input  logic signed [IN_W-1:0]   in_ay,
  input  logic signed [IN_W-1:0]   in_az,
  input  logic signed [IN_W-1:0]   in_bx,
  input  logic signed [IN_W-1:0]   in_by,
  input  logic signed [IN_W-1:0]   in_bz,
  input  logic signed [IN_W-1:0]   in_cx,
  input  logic signed [IN_W-1:0]   in_cy,
  input  logic signed [IN_W-1:0]   in_cz,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed [NORM_W-1:0] out_normal_x,
  output logic signed [NORM_W-1:0] out_normal_y,
  output logic signed [NORM_W-1:0] out_normal_z,
  output logic [DIST_W-1:0]        out_distance
);

  wide_t                    rf_mem [RF_DEPTH];
  wide_t                    rda_r, rdb_r;
  logic signed [IN_W-1:0]   coord_r [NCOORD];
  logic [EPS_W-1:0]         eps_r;
  logic                     ok_r, ok_nxt;
  logic                     found_r, found_nxt;
  logic [DIST_W-1:0]        best_r, best_nxt;
  logic [DIST_W-1:0]        dist_r, dist_nxt;
  logic signed [NORM_W-1:0] bn_r [3];
  logic signed [NORM_W-1:0] bn_nxt [3];
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_hit_r;
  logic signed [NORM_W-1:0] onx_r, ony_r, onz_r;
  logic [DIST_W-1:0]        odist_r;

  logic                     we;
  wide_t                    wd, eps_w, clamp_v, movin_v;
  logic                     unit_start, unit_done;
  wide_t                    unit_res;
  logic [CI_W-1:0]          ci;
  op_t                      op;

  assign op = cmd.ins.op;
  assign ci = cmd.ins.sa[CI_W-1:0];
  assign eps_w = wide_t'({{(W_W-EPS_W){1'b0}}, eps_r});
  assign unit_start = cmd.ex && (op == OP_MUL || op == OP_DIV || op == OP_SQRT);

  rmc_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .op    (op),
    .a     (rda_r),
    .b     (rdb_r),
    .done  (unit_done),
    .res   (unit_res)
  );

  always_comb begin
    movin_v = wide_t'(coord_r[ci]);
    if (rda_r > ONE) clamp_v = ONE;
    else if (rda_r < -ONE) clamp_v = -ONE;
    else clamp_v = rda_r;

    we = 1'b0;
    wd = unit_res;
    ok_nxt = ok_r;
    found_nxt = found_r;
    best_nxt = best_r;
    dist_nxt = dist_r;
    for (int k = 0; k < 3; k++) bn_nxt[k] = bn_r[k];

    if (cmd.unit_wr) we = 1'b1;
    if (cmd.load) ok_nxt = 1'b1;
    if (cmd.ex) begin
      case (op)
        OP_MOVIN: begin
          we = 1'b1;
          wd = movin_v;
        end
        OP_ADD: begin
          we = 1'b1;
          wd = sat_w({rda_r[W_W-1], rda_r} + {rdb_r[W_W-1], rdb_r});
        end
        OP_SUB: begin
          we = 1'b1;
          wd = sat_w({rda_r[W_W-1], rda_r} - {rdb_r[W_W-1], rdb_r});
        end
        OP_CHKDET: ok_nxt = ok_r && (rda_r > eps_w || rda_r < -eps_w);
        OP_CHKNN:  ok_nxt = ok_r && !rda_r[W_W-1];
        OP_CHKLE1: ok_nxt = ok_r && (rda_r <= ONE);
        OP_CHKT: begin
          dist_nxt = (rda_r > DIST_MAX_W) ? {DIST_W{1'b1}} : rda_r[DIST_W-1:0];
          ok_nxt = ok_r && (rda_r >= eps_w) && (dist_nxt < best_r);
        end
        OP_NSET: begin
          if (ok_r) bn_nxt[cmd.ins.dst[1:0]] = clamp_v[NORM_W-1:0];
        end
        OP_FIN: begin
          if (ok_r) begin
            best_nxt = dist_r;
            found_nxt = 1'b1;
          end
        end
        OP_RAYCLR: begin
          best_nxt = {DIST_W{1'b1}};
          found_nxt = 1'b0;
          for (int k = 0; k < 3; k++) bn_nxt[k] = '0;
        end
        default: ;
      endcase
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  // scratch file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) rf_mem[cmd.ins.dst] <= wd;
    if (cmd.rd) begin
      rda_r <= rf_mem[cmd.ins.sa];
      rdb_r <= rf_mem[cmd.ins.sb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r       <= EPS_RESET;
      ok_r        <= 1'b0;
      found_r     <= 1'b0;
      best_r      <= {DIST_W{1'b1}};
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) bn_r[k] <= '0;
    end else begin
      if (cfg_we) eps_r <= cfg_wdata;
      ok_r        <= ok_nxt;
      found_r     <= found_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < 3; k++) bn_r[k] <= bn_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    // zeroed at reset so the ray program run after reset loads a zero ray
    if (!rst_n) begin
      for (int k = 0; k < NCOORD; k++) coord_r[k] <= '0;
    end else if (cmd.load) begin
      coord_r[0] <= in_ax;
      coord_r[1] <= in_ay;
      coord_r[2] <= in_az;
      coord_r[3] <= in_bx;
      coord_r[4] <= in_by;
      coord_r[5] <= in_bz;
      coord_r[6] <= in_cx;
      coord_r[7] <= in_cy;
      coord_r[8] <= in_cz;
    end
    if (cmd.emit) begin
      out_hit_r <= found_r;
      onx_r     <= bn_r[0];
      ony_r     <= bn_r[1];
      onz_r     <= bn_r[2];
      odist_r   <= best_r;
    end
  end

  assign sts.ok        = ok_r;
  assign sts.unit_done = unit_done;
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_normal_x = onx_r;
  assign out_normal_y = ony_r;
  assign out_normal_z = onz_r;
  assign out_distance = odist_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rmc_ctrl.sv =====
// Controller: microprogram sequencer driving the datapath.
`default_nettype none
module rmc_ctrl import rmc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_operation,
  input  logic in_last,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  ctl_state_t        state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              tri_r, tri_nxt;
  logic              last_r, last_nxt;
  logic              fin;

  // out of reset the ray program runs once over zeroed coordinates,
  // which clears the ray registers in the scratch file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_READ;
      pc_r    <= PC_RAY;
      tri_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      tri_r   <= tri_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    tri_nxt   = tri_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.ins   = prog(pc_r);
    in_stall  = (state_r != S_IDLE);
    fin       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          tri_nxt   = in_operation;
          last_nxt  = in_last;
          pc_nxt    = in_operation ? PC_TRI : PC_RAY;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.ex = 1'b1;
        case (cmd.ins.op)
          OP_MUL, OP_DIV, OP_SQRT: state_nxt = S_WAIT;
          OP_END: fin = 1'b1;
          OP_BRNOK: begin
            if (!sts.ok) fin = 1'b1;
            else begin
              pc_nxt    = pc_r + 1'b1;
              state_nxt = S_READ;
            end
          end
          default: begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = S_READ;
          end
        endcase
        if (fin) state_nxt = (tri_r && last_r) ? S_EMIT : S_IDLE;
      end
      S_WAIT: begin
        if (sts.unit_done) begin
          cmd.unit_wr = 1'b1;
          pc_nxt      = pc_r + 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ray_mesh_closest_hit_unit.sv =====
// Top level of the ray/mesh closest hit unit.
`default_nettype none
// Nearest-hit search of one ray against a triangle mesh in signed Q16.16 fixed
// point. A beat with in_operation = 0 loads the ray (origin in a*, direction in
// b*) and resets the best hit to "none, maximum distance"; each beat with
// in_operation = 1 tests triangle (a, b, c) by Cramer's rule with 48-bit
// saturating intermediates and keeps the strictly nearest hit and its unit
// face normal. A triangle beat with in_last set produces one output beat with
// the best hit so far; a ray beat never produces one. cfg_we/cfg_wdata write
// the epsilon tolerance (reset 66) used for the determinant and t tests; write
// it only while the unit is idle. Items are handled one at a time: a microcode
// sequencer steps through a program over a 64-entry scratch file, reading the
// operands of each instruction and then executing it; a multiply (16 bits per
// step), a division (one quotient bit per cycle) or the root waits on the
// shared iterative unit. Right after reset in_stall stays high while the ray
// program runs over zeroed coordinates, so the ray starts at zero. The output
// beat sits in its own register, so the next item is taken while it waits.
module ray_mesh_closest_hit_unit import rmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [EPS_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic signed [IN_W-1:0]   in_ax,
  input  logic signed [IN_W-1:0]   in_ay,
  input  logic signed [IN_W-1:0]   in_az,
  input  logic signed [IN_W-1:0]   in_bx,
  input  logic signed [IN_W-1:0]   in_by,
  input  logic signed [IN_W-1:0]   in_bz,
  input  logic signed [IN_W-1:0]   in_cx,
  input  logic signed [IN_W-1:0]   in_cy,
  input  logic signed [IN_W-1:0]   in_cz,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [NORM_W-1:0] out_normal_x,
  output logic signed [NORM_W-1:0] out_normal_y,
  output logic signed [NORM_W-1:0] out_normal_z,
  output logic [DIST_W-1:0]        out_distance
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one instruction per read/execute pair, waits on the iterative unit
  rmc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_last      (in_last),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // scratch file, arithmetic, hit bookkeeping and the output register
  rmc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_ax        (in_ax),
    .in_ay        (in_ay),
    .in_az        (in_az),
    .in_bx        (in_bx),
    .in_by        (in_by),
    .in_bz        (in_bz),
    .in_cx        (in_cx),
    .in_cy        (in_cy),
    .in_cz        (in_cz),
    .cmd          (cmd),
    .sts          (sts),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z),
    .out_distance (out_distance)
  );

endmodule
`default_nettype wire
